// ===== src/sle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine package
// Shared types and constants for the sorted list engine and its cell chain.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int VALUE_W     = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 16;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_DELETE = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Compare phase broadcast, issued on the input transfer.
    typedef struct packed {
        logic               en;
        logic [VALUE_W-1:0] value;
    } t_cmp_cmd;

    // Update phase broadcast, issued when the command completes.
    typedef struct packed {
        logic               ins;
        logic               del;
        logic [VALUE_W-1:0] value;
    } t_apply_cmd;

endpackage

// ===== src/sle_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine cell
// Holds one entry, compares it against the broadcast value and shifts it
// toward a neighbor on insert or delete.
// ----------------------------------------------------------------------------
module sle_cell #(
    parameter int CW    = 7,
    parameter int INDEX = 0
) (
    input  logic                         i_clk,
    input  sle_pkg::t_cmp_cmd            i_cmp,
    input  sle_pkg::t_apply_cmd          i_apply,
    input  logic [CW-1:0]                i_count,
    input  logic [sle_pkg::VALUE_W-1:0]  i_left_value,
    input  logic                         i_left_le,
    input  logic [sle_pkg::VALUE_W-1:0]  i_right_value,
    output logic [sle_pkg::VALUE_W-1:0]  o_value,
    output logic                         o_le,
    output logic                         o_eq
);
    import sle_pkg::*;

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;
    logic               r_le;
    logic               r_ge;
    logic               r_eq;
    logic               w_active;

    assign w_active = (IDX < i_count);

    always_ff @(posedge i_clk) begin
        if (i_cmp.en) begin
            r_le <= w_active && (r_value <= i_cmp.value);
            r_ge <= w_active && (r_value >= i_cmp.value);
            r_eq <= w_active && (r_value == i_cmp.value);
        end
        r_value <= n_value;
    end

    // Insert: cells above the insertion point take the left neighbor; the
    // first cell above takes the new value. Delete: the matching cell and
    // all above it take the right neighbor.
    always_comb begin
        priority if (i_apply.ins && !r_le) begin
            n_value = i_left_le ? i_apply.value : i_left_value;
        end else if (i_apply.del && r_ge) begin
            n_value = i_right_value;
        end else begin
            n_value = r_value;
        end
    end

    assign o_value = r_value;
    assign o_le    = r_le;
    assign o_eq    = r_eq;

endmodule

// ===== src/sorted_list_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine core
// Ordered multiset of unsigned 32-bit values with insert, find and delete.
// ----------------------------------------------------------------------------
// The engine holds up to CAPACITY values in ascending order in a chain of
// cells, one entry per cell, and takes one command per input transfer. On
// the input transfer every cell compares its entry against the command
// value in parallel; once the output register is free, the cells shift by
// one place toward their neighbors and the result is written to the output
// register. A new command is accepted only after the previous one has
// completed; the output register lets the next command be accepted while a
// result is still waiting. Insert places the value after any equal entries,
// delete removes one matching entry, and find reports presence. Each result
// carries a status (done or found, not found, or full on insert) and the
// entry count after the command, reported modulo 128. An insert into a full
// store leaves it unchanged. Unknown opcodes leave the store unchanged and
// report not found. Entries need no clearing after reset; only cells below
// the entry count are ever observed.
// ----------------------------------------------------------------------------
module sorted_list_engine_core #(
    parameter int CAPACITY = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Command stream. tdata fields from bit 0: opcode[1:0], value[33:2].
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [sle_pkg::S_TDATA_W-1:0] i_s_tdata,
    // Result stream. tdata fields from bit 0: status[1:0], entry_count[8:2].
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [sle_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import sle_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    t_state r_state;
    t_state n_state;

    logic [OP_W-1:0]        r_op;
    logic [VALUE_W-1:0]     r_value;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_m_valid;
    logic [STATUS_W-1:0]    r_m_status;
    logic [COUNT_OUT_W-1:0] r_m_count;
    logic [STATUS_W-1:0]    n_status;

    logic w_in_fire;
    logic w_exec_fire;
    logic w_full;
    logic w_found;

    t_cmp_cmd   w_cmp;
    t_apply_cmd w_apply;

    logic [VALUE_W-1:0] w_cell_value [CAPACITY];
    logic [CAPACITY-1:0] w_cell_le;
    logic [CAPACITY-1:0] w_cell_eq;

    // Sequencer: idle waits for a command, exec completes it once the
    // output register is free.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_m_valid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready  = (r_state == S_IDLE);
        w_exec_fire = (r_state == S_EXEC) && (!r_m_valid || i_m_tready);
    end

    assign w_in_fire = i_s_tvalid && o_s_tready;
    assign w_full    = (r_count >= FULL_COUNT);
    assign w_found   = |w_cell_eq;

    assign w_cmp.en    = w_in_fire;
    assign w_cmp.value = i_s_tdata[OP_W +: VALUE_W];

    // Command decode for the update cycle.
    always_comb begin
        w_apply.ins   = 1'b0;
        w_apply.del   = 1'b0;
        w_apply.value = r_value;
        n_status      = ST_MISSING;
        unique case (r_op)
            OP_INSERT: begin
                w_apply.ins = w_exec_fire && !w_full;
                n_status    = w_full ? ST_FULL : ST_OK;
            end
            OP_FIND: begin
                n_status = w_found ? ST_OK : ST_MISSING;
            end
            OP_DELETE: begin
                w_apply.del = w_exec_fire && w_found;
                n_status    = w_found ? ST_OK : ST_MISSING;
            end
            default: n_status = ST_MISSING;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_apply.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_apply.del) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_exec_fire) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op    <= i_s_tdata[OP_W-1:0];
            r_value <= i_s_tdata[OP_W +: VALUE_W];
        end
        if (w_exec_fire) begin
            r_m_status <= n_status;
            r_m_count  <= COUNT_OUT_W'(n_count);
        end
    end

    // Cell chain. Cell 0 sees an always-true left flag so it takes the new
    // value when it is the insertion point; the top cell reloads itself on
    // delete since nothing lies above it.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_W-1:0] w_left_value;
        logic               w_left_le;
        logic [VALUE_W-1:0] w_right_value;

        if (g == 0) begin : g_first
            assign w_left_value = w_cell_value[g];
            assign w_left_le    = 1'b1;
        end else begin : g_mid
            assign w_left_value = w_cell_value[g-1];
            assign w_left_le    = w_cell_le[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_value = w_cell_value[g];
        end else begin : g_inner
            assign w_right_value = w_cell_value[g+1];
        end

        sle_cell #(
            .CW    (CW),
            .INDEX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmp         (w_cmp),
            .i_apply       (w_apply),
            .i_count       (r_count),
            .i_left_value  (w_left_value),
            .i_left_le     (w_left_le),
            .i_right_value (w_right_value),
            .o_value       (w_cell_value[g]),
            .o_le          (w_cell_le[g]),
            .o_eq          (w_cell_eq[g])
        );
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {(M_TDATA_W - COUNT_OUT_W - STATUS_W)'(0), r_m_count, r_m_status};

endmodule

// ===== src/sle_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine checker
// Port-level assertions on the sorted list engine, bound to the top level.
// ----------------------------------------------------------------------------
module sle_checker #(
    parameter int CAPACITY = 64
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          i_s_tready,
    input logic                          i_m_tvalid,
    input logic                          i_m_tready,
    input logic [sle_pkg::M_TDATA_W-1:0] i_m_tdata
);
    import sle_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
        else $error("result changed while stalled");

    // One command at a time: ready drops right after a transfer.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("command accepted while another was in progress");

    // A result appearing on an idle output stream comes from a command that
    // passed through the exec state without a stall into the output register.
    a_result_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_m_tvalid) |-> $past(i_s_tvalid && i_s_tready, 2))
        else $error("result without a preceding command");

    // The reported count never exceeds the capacity; checked only for capacities below 128.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> ((CAPACITY > 127) ||
                        (int'(i_m_tdata[STATUS_W +: COUNT_OUT_W]) <= CAPACITY)))
        else $error("entry count above capacity");

endmodule

bind sorted_list_engine_core sle_checker #(
    .CAPACITY (CAPACITY)
) u_sle_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
